@@ sv/rgbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbm_pkg: shared types and constants for the 3x3 RGB morphology filter
// Pixel and window types, frame size limits, register indexes and mode codes.
// ----------------------------------------------------------------------------
package rgbm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int CHANNELS   = 3;
    localparam int CHAN_W     = 8;
    localparam int WIN_TAPS   = 9;

    // frame dimensions and position counters
    localparam int DIM_W = 11;
    localparam int COL_W = $clog2(MAX_WIDTH);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd2;

    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    typedef logic [CHAN_W-1:0] chan_t;

    // channel 0 is red in the low byte, then green, then blue
    typedef chan_t [CHANNELS-1:0] pixel_t;

    // window tap q*3+r: column q (0 oldest), row r (0 top)
    typedef pixel_t [WIN_TAPS-1:0] window_t;

    // one line store entry: the two rows above at one column
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
    } line_entry_t;

    // which neighbors lie inside the image
    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } nbr_mask_t;

endpackage

@@ sv/rgbm_in_if.sv @@
// ----------------------------------------------------------------------------
// rgbm_in_if: input pixel channel
// Valid/ready channel carrying one pixel or drain step per word.
// ----------------------------------------------------------------------------
interface rgbm_in_if;

    logic                valid;
    logic                ready;
    logic                action;
    rgbm_pkg::chan_t     red_in;
    rgbm_pkg::chan_t     green_in;
    rgbm_pkg::chan_t     blue_in;

    modport source (
        output valid,
        output action,
        output red_in,
        output green_in,
        output blue_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  red_in,
        input  green_in,
        input  blue_in,
        output ready
    );

endinterface

@@ sv/rgbm_out_if.sv @@
// ----------------------------------------------------------------------------
// rgbm_out_if: filtered pixel channel
// Valid/ready channel carrying one filtered pixel and its frame end flag.
// ----------------------------------------------------------------------------
interface rgbm_out_if;

    logic                valid;
    logic                ready;
    rgbm_pkg::chan_t     red_out;
    rgbm_pkg::chan_t     green_out;
    rgbm_pkg::chan_t     blue_out;
    logic                frame_end;

    modport source (
        output valid,
        output red_out,
        output green_out,
        output blue_out,
        output frame_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  red_out,
        input  green_out,
        input  blue_out,
        input  frame_end,
        output ready
    );

endinterface

@@ sv/rgbm_line_store.sv @@
// ----------------------------------------------------------------------------
// rgbm_line_store: two-row line buffer
// One write port and one registered read port; a read returns the old entry
// when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module rgbm_line_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [rgbm_pkg::COL_W-1:0]    waddr,
    input  rgbm_pkg::line_entry_t         wdata,
    input  logic                          re,
    input  logic [rgbm_pkg::COL_W-1:0]    raddr,
    output rgbm_pkg::line_entry_t         rdata
);

    rgbm_pkg::line_entry_t mem [rgbm_pkg::MAX_WIDTH];
    rgbm_pkg::line_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rgbm_window_reduce.sv @@
// ----------------------------------------------------------------------------
// rgbm_window_reduce: per-channel minimum or maximum over the 3x3 window
// Taps outside the image are masked out of the compare.
// ----------------------------------------------------------------------------
module rgbm_window_reduce (
    input  rgbm_pkg::window_t     window,
    input  rgbm_pkg::nbr_mask_t   mask,
    input  logic                  mode,
    output rgbm_pkg::pixel_t      result
);

    always_comb
    begin
        rgbm_pkg::chan_t acc;
        rgbm_pkg::chan_t v;
        logic            take;
        for (int c = 0; c < rgbm_pkg::CHANNELS; c++)
        begin
            // start from the identity of the chosen operation
            acc = (mode == rgbm_pkg::MODE_MIN) ? '1 : '0;
            for (int q = 0; q < 3; q++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    v    = window[q * 3 + r][c];
                    take = (mode == rgbm_pkg::MODE_MIN) ? (v < acc) : (v > acc);
                    if (mask.col_ok[q] && mask.row_ok[r] && take)
                    begin
                        acc = v;
                    end
                end
            end
            result[c] = acc;
        end
    end

endmodule

@@ sv/rgb_morphology_3x3.sv @@
// ----------------------------------------------------------------------------
// rgb_morphology_3x3: 3x3 per-channel erosion / dilation on an RGB stream
// Raster-order pixels in; the filtered pixel (r,c) leaves with the input word
// for pixel (r+1,c+1), or with drain words after the frame's last pixel.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes the input stage and line store read, then
//   the result word it releases loads the result register. Throughput: 1 word
//   per cycle unless the output stalls, set by the single line store ports.
// Reset: counters, window and valid flags clear; registers return to 1024 x
//   1024, minimum. The line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rgb_morphology_3x3 (
    input  logic                                clk,
    input  logic                                rst_n,
    rgbm_in_if.sink                             pix_in,
    rgbm_out_if.source                          pix_out,
    input  logic                                cfg_we,
    input  logic [rgbm_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [rgbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DW = rgbm_pkg::DIM_W;
    localparam int CW = rgbm_pkg::COL_W;

    // configuration
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic          mode_reg;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic          restart;

    // frame position, tracked at the input
    logic [DW-1:0] in_row_reg,  in_row_next;
    logic [DW-1:0] in_col_reg,  in_col_next;
    logic [DW-1:0] out_row_reg, out_row_next;
    logic [DW-1:0] out_col_reg, out_col_next;

    logic          in_fire;
    logic          in_in_frame;
    logic          in_is_pixel;
    logic          step;
    logic          emit;
    logic          last;
    logic [DW:0]   in_col_inc;
    logic [DW:0]   out_col_inc;
    logic [DW:0]   out_row_inc;
    logic [CW-1:0] col;
    rgbm_pkg::nbr_mask_t mask;
    rgbm_pkg::pixel_t    in_pix;

    // input stage
    logic                  s1_valid_reg;
    logic                  s1_pixel_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;
    rgbm_pkg::nbr_mask_t   s1_mask_reg;
    logic [CW-1:0]         s1_col_reg;
    rgbm_pkg::pixel_t      s1_bot_reg;
    logic                  byp_reg;
    rgbm_pkg::line_entry_t byp_data_reg;
    logic                  s1_go;

    rgbm_pkg::line_entry_t ls_rdata;
    rgbm_pkg::line_entry_t entry;
    rgbm_pkg::line_entry_t wr_entry;

    rgbm_pkg::window_t     win_reg, win_next;
    rgbm_pkg::pixel_t      result;

    // result register
    logic                  out_valid_reg;
    rgbm_pkg::pixel_t      out_pix_reg;
    logic                  out_last_reg;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgbm_pkg::DIM_RESET;
            height_reg <= rgbm_pkg::DIM_RESET;
            mode_reg   <= rgbm_pkg::MODE_MIN;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                rgbm_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                rgbm_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                rgbm_pkg::CFG_MODE:         mode_reg   <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // a new frame size restarts the frame position
    assign restart = cfg_we && (cfg_idx == rgbm_pkg::CFG_IMAGE_WIDTH ||
                                cfg_idx == rgbm_pkg::CFG_IMAGE_HEIGHT);

    assign w_eff = (width_reg == '0) ? DW'(1) :
                   (width_reg > DW'(rgbm_pkg::MAX_WIDTH)) ? DW'(rgbm_pkg::MAX_WIDTH) :
                   width_reg;
    assign h_eff = (height_reg == '0) ? DW'(1) :
                   (height_reg > DW'(rgbm_pkg::MAX_HEIGHT)) ? DW'(rgbm_pkg::MAX_HEIGHT) :
                   height_reg;

    // ------------------------------------------------------------------------
    // input side: classify the word and advance the frame position
    // ------------------------------------------------------------------------
    assign in_fire     = pix_in.valid && pix_in.ready;
    assign in_in_frame = in_row_reg < h_eff;
    assign in_is_pixel = !pix_in.action && in_in_frame;
    // drop a drain word that arrives before the frame's last pixel
    assign step        = in_fire && !(pix_in.action && in_in_frame);

    assign emit = (in_row_reg >= DW'(2)) || (in_row_reg == DW'(1) && in_col_reg != '0);
    assign col  = in_col_reg[CW-1:0];

    assign in_col_inc  = {1'b0, in_col_reg}  + (DW+1)'(1);
    assign out_col_inc = {1'b0, out_col_reg} + (DW+1)'(1);
    assign out_row_inc = {1'b0, out_row_reg} + (DW+1)'(1);

    assign last = emit && (out_row_inc >= {1'b0, h_eff}) && (out_col_inc >= {1'b0, w_eff});

    assign mask.row_ok = {out_row_inc < {1'b0, h_eff}, 1'b1, out_row_reg != '0};
    assign mask.col_ok = {out_col_inc < {1'b0, w_eff}, 1'b1, out_col_reg != '0};

    assign in_pix = in_is_pixel ? {pix_in.blue_in, pix_in.green_in, pix_in.red_in} : '0;

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart)
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (step)
        begin
            if (last)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
            else
            begin
                if (in_col_inc >= {1'b0, w_eff})
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + DW'(1);
                end
                else
                begin
                    in_col_next = in_col_inc[DW-1:0];
                end
                if (emit)
                begin
                    if (out_col_inc >= {1'b0, w_eff})
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_inc[DW-1:0];
                    end
                    else
                    begin
                        out_col_next = out_col_inc[DW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // ------------------------------------------------------------------------
    // input stage and line store
    // ------------------------------------------------------------------------
    assign s1_go        = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || pix_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_pixel_reg <= in_is_pixel;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_mask_reg  <= mask;
            s1_col_reg   <= col;
            s1_bot_reg   <= in_pix;
            // the word ahead writes this column in the same cycle: forward it
            byp_reg      <= s1_valid_reg && s1_pixel_reg && (s1_col_reg == col);
            byp_data_reg <= wr_entry;
        end
    end

    assign entry        = byp_reg ? byp_data_reg : ls_rdata;
    assign wr_entry.top = entry.mid;
    assign wr_entry.mid = s1_bot_reg;

    rgbm_line_store u_line_store (
        .clk   (clk),
        .we    (s1_go && s1_pixel_reg),
        .waddr (s1_col_reg),
        .wdata (wr_entry),
        .re    (step),
        .raddr (col),
        .rdata (ls_rdata)
    );

    // ------------------------------------------------------------------------
    // window shift and reduction
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            win_next[k] = win_reg[k + 3];
        end
        win_next[6] = entry.top;
        win_next[7] = entry.mid;
        win_next[8] = s1_bot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_go)
        begin
            win_reg <= win_next;
        end
    end

    rgbm_window_reduce u_reduce (
        .window (win_next),
        .mask   (s1_mask_reg),
        .mode   (mode_reg),
        .result (result)
    );

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_pix_reg  <= result;
            out_last_reg <= s1_last_reg;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_pix_reg[0];
    assign pix_out.green_out = out_pix_reg[1];
    assign pix_out.blue_out  = out_pix_reg[2];
    assign pix_out.frame_end = out_last_reg;

`ifndef ASSERT_OFF
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_col_reg < w_eff)
        else $error("input column outside the image width");

    a_bypass_width_one: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && byp_reg) |-> (w_eff == DW'(1)))
        else $error("line store forward with image width above one");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emit_reg) |=> out_valid_reg)
        else $error("result word lost between input stage and result register");
`endif

endmodule

@@ sim/tb_rgb_morphology_3x3.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_morphology_3x3: self-checking bench for the 3x3 RGB morphology filter
// Streams raster frames of random RGB words with drain words, early drains and
// truncated frames over many frame sizes and both modes. A behavioral window
// filter predicts every filtered word, and each accepted result is matched
// field by field against it. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
import rgbm_pkg::*;

localparam logic ACT_PIXEL = 1'b0;
localparam logic ACT_DRAIN = 1'b1;

// zero counts as one, anything above the limit counts as the limit
function automatic int unsigned dim_in_use(input int unsigned val, input int unsigned limit);
    if (val == 0)
        return 1;
    if (val > limit)
        return limit;
    return val;
endfunction

class window_filter_check;

    typedef struct packed {
        pixel_t px;
        logic   frame_end;
    } filtered_t;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             mode_reg;
    line_entry_t      line_mem [MAX_WIDTH];
    window_t          win;
    int unsigned      in_row;
    int unsigned      in_col;
    int unsigned      out_row;
    int unsigned      out_col;
    filtered_t        due_pixels [$];
    int unsigned      errors;

    function new();
        width_reg  = DIM_RESET;
        height_reg = DIM_RESET;
        mode_reg   = MODE_MIN;
        win        = '0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        restart();
        errors = 0;
    endfunction

    function void restart();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:
            begin
                width_reg = data;
                restart();
            end
            CFG_IMAGE_HEIGHT:
            begin
                height_reg = data;
                restart();
            end
            CFG_MODE:
                mode_reg = data[0];
            default:
                ;
        endcase
    endfunction

    function int unsigned pending();
        return due_pixels.size();
    endfunction

    // advance the window by one word; returns 1 when a filtered word falls out
    function bit filter_step(input logic act, input pixel_t px, output filtered_t res);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        bit          is_pix;
        bit          emit;
        line_entry_t ent;
        bit [2:0]    row_ok;
        bit [2:0]    col_ok;
        chan_t       acc;
        chan_t       v;

        res    = '0;
        w      = dim_in_use(width_reg, MAX_WIDTH);
        h      = dim_in_use(height_reg, MAX_HEIGHT);
        is_pix = (act == ACT_PIXEL) && (in_row < h);
        // drain before the frame's last pixel: ignored
        if (!is_pix && in_row < h)
            return 0;

        col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
        ent = line_mem[col];
        for (int k = 0; k < 6; k++)
            win[k] = win[k + 3];
        win[6] = ent.top;
        win[7] = ent.mid;
        win[8] = is_pix ? px : '0;
        if (is_pix)
            line_mem[col] = '{top: ent.mid, mid: px};

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (!emit)
            return 0;

        row_ok = {out_row + 1 < h, 1'b1, out_row >= 1};
        col_ok = {out_col + 1 < w, 1'b1, out_col >= 1};
        for (int c = 0; c < CHANNELS; c++)
        begin
            acc = (mode_reg == MODE_MIN) ? 8'hFF : 8'h00;
            for (int q = 0; q < 3; q++)
                for (int r = 0; r < 3; r++)
                    if (col_ok[q] && row_ok[r])
                    begin
                        v = win[q * 3 + r][c];
                        if ((mode_reg == MODE_MIN) ? (v < acc) : (v > acc))
                            acc = v;
                    end
            res.px[c] = acc;
        end

        res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (res.frame_end)
            restart();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    function void take_word(input logic act, input pixel_t px);
        filtered_t res;

        if (filter_step(act, px, res))
            due_pixels.push_back(res);
    endfunction

    function void match_result(input pixel_t px, input logic frame_end);
        filtered_t due;

        if (due_pixels.size() == 0)
        begin
            $error("result word with none due: red %0d green %0d blue %0d frame_end %0b",
                   px[0], px[1], px[2], frame_end);
            errors++;
            return;
        end
        due = due_pixels.pop_front();
        if (px[0] !== due.px[0])
        begin
            $error("red_out: expected %0d, actual %0d", due.px[0], px[0]);
            errors++;
        end
        if (px[1] !== due.px[1])
        begin
            $error("green_out: expected %0d, actual %0d", due.px[1], px[1]);
            errors++;
        end
        if (px[2] !== due.px[2])
        begin
            $error("blue_out: expected %0d, actual %0d", due.px[2], px[2]);
            errors++;
        end
        if (frame_end !== due.frame_end)
        begin
            $error("frame_end: expected %0b, actual %0b", due.frame_end, frame_end);
            errors++;
        end
    endfunction

endclass

module tb_rgb_morphology_3x3;

    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned ITEM_TARGET  = 900;
    localparam int unsigned BIG_CUT      = 48;
    localparam int unsigned NO_CUT       = 32'hFFFF_FFFF;

    localparam chan_t SEED_RED   [9] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F,
                                         8'hFE, 8'h55, 8'hAA, 8'h10};
    localparam chan_t SEED_GREEN [9] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01,
                                         8'h80, 8'hFE, 8'h7F, 8'hEF};
    localparam chan_t SEED_BLUE  [9] = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'hAA,
                                         8'h55, 8'h01, 8'hFE, 8'h08};

    localparam int unsigned BIG_W [4] = '{1024, 2047, 1, 1};
    localparam int unsigned BIG_H [4] = '{1, 1, 1024, 2047};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgbm_in_if  px_in ();
    rgbm_out_if px_out ();

    window_filter_check wf_check;

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned quiet_cycles;
    int unsigned frame_no;
    int unsigned sent_words;
    int unsigned cur_w;
    int unsigned cur_h;
    bit          frame_open;

    rgb_morphology_3x3 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (px_in),
        .pix_out  (px_out),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        px_out.ready <= ($urandom_range(99) >= snk_stall_pct);

    // monitor both channels and watch for a stuck pipeline
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (px_in.valid && px_in.ready)
                wf_check.take_word(px_in.action,
                                   {px_in.blue_in, px_in.green_in, px_in.red_in});
            if (px_out.valid && px_out.ready)
                wf_check.match_result({px_out.blue_out, px_out.green_out, px_out.red_out},
                                      px_out.frame_end);
            if ((px_in.valid && px_in.ready) || (px_out.valid && px_out.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    function automatic chan_t rand_chan();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic int unsigned pick_dim(input int unsigned top);
        int unsigned r;

        r = $urandom_range(15);
        if (r == 0)
            return 0;
        if (r <= 10)
            return $urandom_range(5, 1);
        return $urandom_range(top, 6);
    endfunction

    task automatic set_phase(input int unsigned p);
        case (p % 4)
            0:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct  = 49;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 49;
            end
            default:
            begin
                src_idle_pct  = 31;
                snk_stall_pct = 31;
            end
        endcase
    endtask

    // hold a word on the channel until it is taken
    task automatic send_word(input logic act, input pixel_t px);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            px_in.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        px_in.valid    <= 1'b1;
        px_in.action   <= act;
        px_in.red_in   <= px[0];
        px_in.green_in <= px[1];
        px_in.blue_in  <= px[2];
        do
            @(posedge clk);
        while (!px_in.ready);
        sent_words++;
    endtask

    // drop valid and wait until every due word is out and the pipe is empty
    task automatic settle();
        px_in.valid <= 1'b0;
        @(posedge clk);
        while (wf_check.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        wf_check.write_reg(idx, data);
    endtask

    task automatic set_geometry(input int unsigned w_val, input int unsigned h_val);
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
        cur_w = dim_in_use(w_val & 32'h7FF, MAX_WIDTH);
        cur_h = dim_in_use(h_val & 32'h7FF, MAX_HEIGHT);
        frame_open = 1'b0;
    endtask

    // one frame of random pixels, then drains; stop early at the cut
    task automatic send_frame(input int unsigned cut, input bit noisy);
        int unsigned npix;
        int unsigned mode_at;

        npix = cur_w * cur_h;
        if (noisy && $urandom_range(3) == 0)
            mode_at = $urandom_range(npix - 1);
        else
            mode_at = npix;
        for (int unsigned i = 0; i < npix; i++)
        begin
            if (i == cut)
            begin
                frame_open = 1'b1;
                return;
            end
            if (i == mode_at)
                cfg_write(CFG_MODE, CFG_DATA_W'($urandom_range(1)));
            // early drain, ignored by the block
            if (noisy && $urandom_range(19) == 0)
                send_word(ACT_DRAIN, rand_pixel());
            send_word(ACT_PIXEL, rand_pixel());
        end
        // a pixel after the frame's last one acts as a drain
        for (int unsigned i = 0; i <= cur_w; i++)
            send_word(($urandom_range(7) == 0) ? ACT_PIXEL : ACT_DRAIN, rand_pixel());
        if (noisy && $urandom_range(3) == 0)
            send_word(ACT_DRAIN, rand_pixel());
        frame_open = 1'b0;
    endtask

    task automatic random_frame();
        int unsigned cut;

        set_phase(frame_no);
        frame_no++;
        if (frame_open || $urandom_range(2) != 0)
            set_geometry(pick_dim(16), pick_dim(8));
        if ($urandom_range(1) != 0)
            cfg_write(CFG_MODE, CFG_DATA_W'($urandom_range(1)));
        if ($urandom_range(4) == 0)
            cut = $urandom_range(cur_w * cur_h - 1);
        else
            cut = NO_CUT;
        send_frame(cut, 1'b1);
    endtask

    initial
    begin
        wf_check       = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        px_in.valid    = 1'b0;
        px_in.action   = ACT_PIXEL;
        px_in.red_in   = '0;
        px_in.green_in = '0;
        px_in.blue_in  = '0;
        px_out.ready   = 1'b0;
        quiet_cycles   = 0;
        frame_no       = 0;
        sent_words     = 0;
        frame_open     = 1'b0;
        set_phase(0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry is 1024 x 1024: a few pixels and an early drain, no output
        send_word(ACT_PIXEL, {8'h00, 8'hFF, 8'h00});
        send_word(ACT_PIXEL, {8'hFF, 8'h00, 8'hFF});
        send_word(ACT_DRAIN, {8'h00, 8'h00, 8'h00});
        send_word(ACT_PIXEL, {8'hFF, 8'hFF, 8'hFF});

        // 3 x 3 frame with extreme channel values, mode switched mid-frame
        set_geometry(3, 3);
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_MIN));
        for (int i = 0; i < 9; i++)
        begin
            if (i == 5)
                cfg_write(CFG_MODE, CFG_DATA_W'(MODE_MAX));
            send_word(ACT_PIXEL, {SEED_BLUE[i], SEED_GREEN[i], SEED_RED[i]});
        end
        send_word(ACT_DRAIN, {8'h00, 8'h00, 8'h00});
        send_word(ACT_PIXEL, {8'hFF, 8'hFF, 8'hFF});
        send_word(ACT_DRAIN, {8'hFF, 8'h00, 8'hFF});
        send_word(ACT_DRAIN, {8'h00, 8'hFF, 8'h00});
        // drain after the frame is done: ignored
        send_word(ACT_DRAIN, {8'h00, 8'h00, 8'h00});

        // zero size counts as a single pixel; first drain only advances
        set_geometry(0, 0);
        send_word(ACT_PIXEL, {8'h12, 8'hFF, 8'h00});
        send_word(ACT_DRAIN, {8'h00, 8'h00, 8'h00});
        send_word(ACT_DRAIN, {8'h00, 8'h00, 8'h00});

        // largest and clamped geometries, the start of one frame each
        for (int j = 0; j < 4; j++)
        begin
            set_phase(j);
            set_geometry(BIG_W[j], BIG_H[j]);
            cfg_write(CFG_MODE, CFG_DATA_W'($urandom_range(1)));
            send_frame(BIG_CUT, 1'b0);
        end

        while (sent_words < ITEM_TARGET)
            random_frame();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (wf_check.errors == 0 && wf_check.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
sv/rgbm_pkg.sv
sv/rgbm_in_if.sv
sv/rgbm_out_if.sv
sv/rgbm_line_store.sv
sv/rgbm_window_reduce.sv
sv/rgb_morphology_3x3.sv
sim/tb_rgb_morphology_3x3.sv
